/* rtl/core/btmx_pkg.sv */
package btmx_pkg;

   // Fixed key width; one trie level per key bit
   localparam int KEY_BITS         = 32;
   localparam int LEVEL_BITS       = $clog2(KEY_BITS);
   localparam int NODE_COUNT_DEF   = 4096;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_POOL_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_WALK = 2'd1,
      ST_DONE = 2'd2
   } state_type;

endpackage

/* rtl/core/binary_trie_max_xor.sv */
// Maximum-XOR trie. Keys arrive on the req_ channel: tuser carries the operation
// (0 insert, 1 query) and tdata the signed 32-bit key. Each accepted transaction
// yields exactly one rsp_ transaction: tdata holds the query key XOR the best
// stored key (zero for inserts and errors), tuser the status (0 ok, 1 query on
// an empty trie, 2 node pool full and insert dropped).
// One item is processed at a time. An insert or query walks the 32 trie levels
// at one level per cycle, limited by the single read port of the node store;
// an error skips the walk and goes straight to the result. req_tready is high
// only in the idle state, so the next transaction is taken while a finished
// result still waits in the output register. A stalled receiver holds the
// result there; a further finished result waits in its last state until that
// register drains.
// Reset empties the trie: the root's links live in flip-flops and clear at
// once, the allocator restarts at node 1, and no clearing pass runs, since a
// fresh node reads as empty until its links are first written in full.
// Inserts are refused once fewer than 32 nodes remain free.
module binary_trie_max_xor
   import btmx_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [KEY_BITS-1:0] req_tdata,   // [31:0] key
   input  logic [0:0]          req_tuser,   // [0] op
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [KEY_BITS-1:0] rsp_tdata,   // [31:0] xor_result
   output logic [1:0]          rsp_tuser    // [1:0] status
);

   localparam int ADDR_BITS  = $clog2(NODE_COUNT);
   localparam int ENTRY_BITS = 2 * ADDR_BITS;
   localparam int FREE_BITS  = $clog2(NODE_COUNT + 1);
   localparam int TOP_LEVEL  = KEY_BITS - 1;

   // control state
   state_type              state_ff, state_in;
   logic [LEVEL_BITS-1:0]  level_ff, level_in;
   logic [ADDR_BITS-1:0]   node_ff, node_in;
   logic                   fresh_ff, fresh_in;
   logic [FREE_BITS-1:0]   next_free_ff, next_free_in;
   logic                   nonempty_ff, nonempty_in;
   logic [ENTRY_BITS-1:0]  root_ff, root_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload
   op_type                 op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [KEY_BITS-1:0]    found_ff, found_in;
   status_type             status_ff, status_in;
   logic [KEY_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   // node store port
   logic                   wr_en;
   logic [ENTRY_BITS-1:0]  wr_data;
   logic                   rd_en;
   logic [ENTRY_BITS-1:0]  rd_data;

   // walk datapath
   logic [ENTRY_BITS-1:0]  entry;
   logic [ADDR_BITS-1:0]   link0, link1;
   logic                   kbit, pref, take, alloc, accept, pool_full;
   logic [ADDR_BITS-1:0]   ins_link, ins_next, plink, q_next;
   logic [ENTRY_BITS-1:0]  new_entry;

   btmx_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (node_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (node_in),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign pool_full = next_free_ff > FREE_BITS'(NODE_COUNT - KEY_BITS);

   // Links of the node at the current level: root from flops, a freshly
   // allocated node is known empty, anything else comes from the store.
   always_comb begin
      if (level_ff == LEVEL_BITS'(TOP_LEVEL)) begin
         entry = root_ff;
      end else if (fresh_ff) begin
         entry = '0;
      end else begin
         entry = rd_data;
      end
   end

   assign link0 = entry[ADDR_BITS-1:0];
   assign link1 = entry[ENTRY_BITS-1:ADDR_BITS];
   assign kbit  = key_ff[level_ff];

   // insert: follow or allocate the child on the key's bit
   assign ins_link  = kbit ? link1 : link0;
   assign alloc     = (ins_link == '0);
   assign ins_next  = alloc ? next_free_ff[ADDR_BITS-1:0] : ins_link;
   assign new_entry = kbit ? {ins_next, link0} : {link1, ins_next};

   // query: same bit at the sign level, opposite bit below; fall back if absent
   assign pref   = (level_ff == LEVEL_BITS'(TOP_LEVEL)) ? kbit : ~kbit;
   assign plink  = pref ? link1 : link0;
   assign take   = (plink == '0) ? ~pref : pref;
   assign q_next = take ? link1 : link0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         node_ff      <= '0;
         fresh_ff     <= 1'b0;
         next_free_ff <= FREE_BITS'(1);
         nonempty_ff  <= 1'b0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         node_ff      <= node_in;
         fresh_ff     <= fresh_in;
         next_free_ff <= next_free_in;
         nonempty_ff  <= nonempty_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      node_in      = node_ff;
      fresh_in     = fresh_ff;
      next_free_in = next_free_ff;
      nonempty_in  = nonempty_ff;
      root_in      = root_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;
      wr_data      = new_entry;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_tuser[0]);
               key_in   = req_tdata;
               found_in = '0;
               level_in = LEVEL_BITS'(TOP_LEVEL);
               node_in  = '0;
               fresh_in = 1'b0;
               if (op_type'(req_tuser[0]) == OP_INSERT && pool_full) begin
                  status_in = STATUS_POOL_FULL;
                  state_in  = ST_DONE;
               end else if (op_type'(req_tuser[0]) == OP_QUERY && !nonempty_ff) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_DONE;
               end else begin
                  status_in = STATUS_OK;
                  state_in  = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            // one level per cycle; read the child for the next level
            rd_en = 1'b1;
            if (op_ff == OP_INSERT) begin
               node_in  = ins_next;
               fresh_in = alloc;
               if (alloc) begin
                  next_free_in = next_free_ff + FREE_BITS'(1);
                  if (node_ff == '0) begin
                     root_in = new_entry;
                  end else begin
                     wr_en = 1'b1;
                  end
               end
            end else begin
               node_in            = q_next;
               found_in[level_ff] = take;
            end
            if (level_ff == '0) begin
               if (op_ff == OP_INSERT) begin
                  nonempty_in = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               level_in = level_ff - LEVEL_BITS'(1);
            end
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               if (status_ff == STATUS_OK && op_ff == OP_QUERY) begin
                  rsp_data_in = key_ff ^ found_ff;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/btmx_ram.sv */
module btmx_ram
   import btmx_pkg::*;
#(
   parameter int WIDTH = 2 * $clog2(NODE_COUNT_DEF),
   parameter int DEPTH = NODE_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
